// ===== src/angular_cone_search_macros.svh =====
// assertion helpers used by angular_cone_search
`ifndef ANGULAR_CONE_SEARCH_MACROS_SVH
`define ANGULAR_CONE_SEARCH_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define ACS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define ACS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/acs_pkg.sv =====
package acs_pkg;

    // datapath width of the shared arithmetic units
    localparam int DW = 40;
    // index width of the arctangent table
    localparam int IW = 6;
    localparam int ATAN_DEPTH = 40;
    localparam int DIV_TOP = 60;

    localparam logic signed [DW-1:0] QUARTER_TURN = 40'sd1073741824;
    localparam logic signed [DW-1:0] HALF_TURN    = 40'sd2147483648;
    localparam logic signed [DW-1:0] ONE_Q30      = 40'sd1073741824;

    localparam logic [31:0] ATAN_TURNS [ATAN_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1,
        32'd1, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_HIT       = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_READ_OK   = 2'd2;
    localparam logic [1:0] ST_READ_MISS = 2'd3;

    localparam logic [2:0] MUL_LAST = 3'd6;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         slot;
        logic [31:0]        ra;
        logic signed [31:0] dec;
        logic [31:0]        radius;
        logic               want_bodies;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         result_index;
        logic [31:0]        body_ra;
        logic signed [31:0] body_dec;
        logic [31:0]        separation;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic                  flip;
        logic signed [DW-1:0]  z;
    } red_t;

    typedef enum logic [3:0] {
        S_INIT_VEC,
        S_INIT_DIV,
        S_IDLE,
        S_READ,
        S_Q_SC1,
        S_B_SC2,
        S_B_SC3,
        S_B_MUL,
        S_B_VEC1,
        S_B_MULG,
        S_B_VEC2,
        S_B_CHECK,
        S_Q_END
    } state_t;

    function automatic logic signed [DW-1:0] atan_at(input logic [IW-1:0] idx);
        return $signed({{(DW-32){1'b0}}, ATAN_TURNS[idx]});
    endfunction

    // bring an angle into plus or minus a quarter turn
    function automatic red_t reduce_angle(input logic [31:0] ang);
        red_t r;
        logic signed [31:0] s;
        s = $signed(ang);
        r.z = DW'(s);
        r.flip = 1'b0;
        if (r.z > QUARTER_TURN)
        begin
            r.z = r.z - HALF_TURN;
            r.flip = 1'b1;
        end
        else if (r.z < -QUARTER_TURN)
        begin
            r.z = r.z + HALF_TURN;
            r.flip = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== src/acs_cordic.sv =====
module acs_cordic
    import acs_pkg::*;
#(
    parameter int STEPS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 vec,
    input  logic signed [DW-1:0] x0,
    input  logic signed [DW-1:0] y0,
    input  logic signed [DW-1:0] z0,
    output logic signed [DW-1:0] x,
    output logic signed [DW-1:0] y,
    output logic signed [DW-1:0] z,
    output logic                 done
);

    logic signed [DW-1:0] x_reg, y_reg, z_reg;
    logic [IW-1:0]        i_reg;
    logic                 busy_reg, done_reg;
    logic signed [DW-1:0] xs, ys, ang;
    logic                 sel;

    assign xs  = x_reg >>> i_reg;
    assign ys  = y_reg >>> i_reg;
    assign ang = atan_at(i_reg);
    // vectoring drives y to zero, rotation drives z to zero
    assign sel = vec ? (y_reg > 0) : (z_reg < 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x0;
            y_reg <= y0;
            z_reg <= z0;
        end
        else if (busy_reg)
        begin
            if (sel)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign done = done_reg;

endmodule

// ===== src/acs_mul.sv =====
module acs_mul
    import acs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] a,
    input  logic signed [DW-1:0] b,
    output logic signed [DW-1:0] p,
    output logic                 done
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]        ua_reg, ub_reg, hi_reg, lo_reg;
    logic                 neg_reg, busy_reg, done_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [DW-1:0] p_reg;
    logic [DW:0]          sum;
    logic [2*DW-1:0]      prod, sprod;

    // one multiplier bit a cycle, partial sum shifts right
    assign sum   = {1'b0, hi_reg} + (ub_reg[0] ? {1'b0, ua_reg} : '0);
    assign prod  = {hi_reg, lo_reg};
    assign sprod = neg_reg ? (~prod + 1'b1) : prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(DW))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= a[DW-1] ? -a : a;
            ub_reg  <= b[DW-1] ? -b : b;
            neg_reg <= a[DW-1] ^ b[DW-1];
            hi_reg  <= '0;
            lo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(DW))
            begin
                // floor shift by thirty bits of the exact product
                p_reg <= $signed(sprod[30 +: DW]);
            end
            else
            begin
                hi_reg <= sum[DW:1];
                lo_reg <= {sum[0], lo_reg[DW-1:1]};
                ub_reg <= ub_reg >> 1;
            end
        end
    end

    assign p    = p_reg;
    assign done = done_reg;

endmodule

// ===== src/acs_div.sv =====
module acs_div
    import acs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] den,
    output logic [DW-1:0] quo,
    output logic          done
);

    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg, quo_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   shifted;
    logic          ge;

    // dividend is a single one at the top bit position
    assign shifted = {rem_reg[DW-1:0], (cnt_reg == 6'(DIV_TOP))};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_TOP);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - {1'b0, den_reg}) : shifted;
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ===== src/angular_cone_search.sv =====
// cone search over a small table of body sky positions
// cmd channel (cmd_valid, cmd_stall, cmd_word) carries one command word:
// load a body, run a cone query, or read one body back
// rsp channel (rsp_valid, rsp_stall, rsp_word) returns result words; the
// final word of each command has last set
// a load gives no word; a read gives one word, loaded into the output
// register from the read state
// a query walks every body on one rotation/vectoring cordic unit and one
// bit-serial multiplier: per body two rotations, two vectorings and eight
// products, plus one rotation at start
// the cmd channel stalls until the command is finished
// after reset the block first derives the cordic gain correction with a
// vectoring pass and a 61-step restoring division and stalls cmd
// meanwhile; the body table resets to zero
// a stalled rsp word holds; the sequencer waits while the output register
// is full, except that one hit is buffered so last can be marked
module angular_cone_search
    import acs_pkg::*;
#(
    parameter int BODY_COUNT   = 9,
    parameter int CORDIC_STEPS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  in_word_t  cmd_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_word_t rsp_word
);

    localparam int BW = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;

    state_t state_reg, state_next;

    logic [31:0] sra_reg [BODY_COUNT];
    logic [31:0] sdec_reg [BODY_COUNT];
    logic        has_data_reg;
    in_word_t    q_reg;
    logic [BW-1:0] body_reg;
    logic [2:0]  mul_idx_reg;
    logic        issued_reg;
    logic [DW-1:0] g_reg;
    logic signed [DW-1:0] sd1_reg, cd1_reg, sd2_reg, cd2_reg, sdra_reg, cdra_reg;
    logic signed [DW-1:0] a_reg, b_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [DW-1:0] xv_reg, yv_reg, mag_reg;
    logic [31:0] sep_reg;
    logic        pend_valid_reg;
    out_word_t   pend_reg;
    logic        rsp_valid_reg;
    out_word_t   rsp_word_reg;

    logic accept, out_free, unit_go, hit, load_out, in_range, last_body;
    logic cor_start, cor_vec, cor_done, mul_start, mul_done, div_start, div_done;
    logic signed [DW-1:0] cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;
    logic signed [DW-1:0] mul_a, mul_b, mul_p;
    logic [DW-1:0] div_den, div_quo;
    logic [31:0] cur_angle;
    red_t        red;
    out_word_t   out_next, hit_word;
    logic signed [DW-1:0] rs, rc;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign unit_go   = !issued_reg;
    assign in_range  = {1'b0, q_reg.slot} < 5'(BODY_COUNT);
    assign last_body = (body_reg == BW'(BODY_COUNT - 1));
    assign hit       = (sep_reg <= q_reg.radius);
    assign red       = reduce_angle(cur_angle);
    assign rs        = red.flip ? -cor_y : cor_y;
    assign rc        = red.flip ? -cor_x : cor_x;

    always_comb
    begin
        hit_word.status       = ST_HIT;
        hit_word.result_index = 4'(body_reg);
        hit_word.body_ra      = sra_reg[body_reg];
        hit_word.body_dec     = $signed(sdec_reg[body_reg]);
        hit_word.separation   = sep_reg;
        hit_word.last         = 1'b0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT_VEC: if (cor_done) state_next = S_INIT_DIV;
            S_INIT_DIV: if (div_done) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_word.cmd)
                        CMD_QUERY:
                            state_next = (cmd_word.want_bodies && has_data_reg) ?
                                         S_Q_SC1 : S_Q_END;
                        CMD_READ: state_next = S_READ;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:    if (out_free) state_next = S_IDLE;
            S_Q_SC1:   if (cor_done) state_next = S_B_SC2;
            S_B_SC2:   if (cor_done) state_next = S_B_SC3;
            S_B_SC3:   if (cor_done) state_next = S_B_MUL;
            S_B_MUL:   if (mul_done && mul_idx_reg == MUL_LAST) state_next = S_B_VEC1;
            S_B_VEC1:  if (cor_done) state_next = S_B_MULG;
            S_B_MULG:  if (mul_done) state_next = S_B_VEC2;
            S_B_VEC2:  if (cor_done) state_next = S_B_CHECK;
            S_B_CHECK:
            begin
                if (!(hit && pend_valid_reg && !out_free))
                    state_next = last_body ? S_Q_END : S_B_SC2;
            end
            S_Q_END:   if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // unit control and operand selection
    always_comb
    begin
        cor_start = 1'b0;
        cor_vec   = 1'b0;
        cor_x0    = '0;
        cor_y0    = '0;
        cor_z0    = '0;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_den   = (mag_reg < 1) ? DW'(1) : mag_reg;
        cur_angle = q_reg.dec;
        load_out  = 1'b0;
        out_next  = hit_word;
        unique case (state_reg)
            S_INIT_VEC:
            begin
                cor_start = unit_go;
                cor_vec   = 1'b1;
                cor_x0    = ONE_Q30;
            end
            S_INIT_DIV: div_start = unit_go;
            S_READ:
            begin
                load_out = out_free;
                if (has_data_reg && in_range)
                begin
                    out_next.status       = ST_READ_OK;
                    out_next.body_ra      = sra_reg[q_reg.slot[BW-1:0]];
                    out_next.body_dec     = $signed(sdec_reg[q_reg.slot[BW-1:0]]);
                end
                else
                begin
                    out_next.status   = ST_READ_MISS;
                    out_next.body_ra  = '0;
                    out_next.body_dec = '0;
                end
                out_next.result_index = q_reg.slot;
                out_next.separation   = '0;
                out_next.last         = 1'b1;
            end
            S_Q_SC1, S_B_SC2, S_B_SC3:
            begin
                if (state_reg == S_B_SC2)
                    cur_angle = sdec_reg[body_reg];
                else if (state_reg == S_B_SC3)
                    cur_angle = sra_reg[body_reg] - q_reg.ra;
                cor_start = unit_go;
                cor_x0    = $signed(g_reg);
                cor_z0    = red.z;
            end
            S_B_MUL:
            begin
                mul_start = unit_go;
                case (mul_idx_reg)
                    3'd0:    begin mul_a = cd2_reg; mul_b = sdra_reg; end
                    3'd1:    begin mul_a = cd1_reg; mul_b = sd2_reg;  end
                    3'd2:    begin mul_a = sd1_reg; mul_b = cd2_reg;  end
                    3'd3:    begin mul_a = t2_reg;  mul_b = cdra_reg; end
                    3'd4:    begin mul_a = sd1_reg; mul_b = sd2_reg;  end
                    3'd5:    begin mul_a = cd1_reg; mul_b = cd2_reg;  end
                    default: begin mul_a = t4_reg;  mul_b = cdra_reg; end
                endcase
            end
            S_B_VEC1:
            begin
                cor_start = unit_go;
                cor_vec   = 1'b1;
                cor_x0    = a_reg[DW-1] ? -a_reg : a_reg;
                cor_y0    = b_reg[DW-1] ? -b_reg : b_reg;
            end
            S_B_MULG:
            begin
                mul_start = unit_go;
                mul_a     = mag_reg;
                mul_b     = $signed(g_reg);
            end
            S_B_VEC2:
            begin
                cor_start = unit_go;
                cor_vec   = 1'b1;
                // a negative x is first turned by a quarter turn
                if (xv_reg < 0)
                begin
                    cor_x0 = yv_reg;
                    cor_y0 = -xv_reg;
                    cor_z0 = QUARTER_TURN;
                end
                else
                begin
                    cor_x0 = xv_reg;
                    cor_y0 = yv_reg;
                end
            end
            S_B_CHECK:
            begin
                load_out = hit && pend_valid_reg && out_free;
                out_next = pend_reg;
            end
            S_Q_END:
            begin
                load_out = out_free;
                if (pend_valid_reg)
                begin
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                end
                else
                begin
                    out_next.status       = ST_NONE;
                    out_next.result_index = '0;
                    out_next.body_ra      = '0;
                    out_next.body_dec     = '0;
                    out_next.separation   = '0;
                    out_next.last         = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT_VEC;
            issued_reg     <= 1'b0;
            has_data_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            body_reg       <= '0;
            mul_idx_reg    <= '0;
            for (int k = 0; k < BODY_COUNT; k++)
            begin
                sra_reg[k]  <= '0;
                sdec_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cor_start || mul_start || div_start)
                issued_reg <= 1'b1;
            else if (cor_done || mul_done || div_done)
                issued_reg <= 1'b0;

            // cleared when taken, set when a new word is loaded
            rsp_valid_reg <= load_out || (rsp_valid_reg && rsp_stall);

            if (accept && cmd_word.cmd == CMD_LOAD &&
                {1'b0, cmd_word.slot} < 5'(BODY_COUNT))
            begin
                sra_reg[cmd_word.slot[BW-1:0]]  <= cmd_word.ra;
                sdec_reg[cmd_word.slot[BW-1:0]] <= cmd_word.dec;
                has_data_reg <= 1'b1;
            end

            if (state_reg == S_Q_SC1)
                body_reg <= '0;
            if (state_reg == S_B_SC3 || state_reg == S_B_VEC1)
                mul_idx_reg <= '0;
            else if (state_reg == S_B_MUL && mul_done)
                mul_idx_reg <= mul_idx_reg + 1'b1;

            if (state_reg == S_B_CHECK && state_next != S_B_CHECK)
            begin
                if (!last_body)
                    body_reg <= body_reg + 1'b1;
                if (hit)
                    pend_valid_reg <= 1'b1;
            end
            if (state_reg == S_Q_END && out_free)
                pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg <= cmd_word;
        if (load_out)
            rsp_word_reg <= out_next;
        if (state_reg == S_B_CHECK && hit && state_next != S_B_CHECK)
            pend_reg <= hit_word;
        if (cor_done)
        begin
            unique case (state_reg)
                S_INIT_VEC, S_B_VEC1: mag_reg <= cor_x;
                S_Q_SC1: begin sd1_reg  <= rs; cd1_reg  <= rc; end
                S_B_SC2: begin sd2_reg  <= rs; cd2_reg  <= rc; end
                S_B_SC3: begin sdra_reg <= rs; cdra_reg <= rc; end
                S_B_VEC2:
                begin
                    if (cor_z < 0)
                        sep_reg <= '0;
                    else if (cor_z > HALF_TURN)
                        sep_reg <= 32'h8000_0000;
                    else
                        sep_reg <= cor_z[31:0];
                end
                default: ;
            endcase
        end
        if (div_done)
            g_reg <= div_quo;
        if (mul_done)
        begin
            if (state_reg == S_B_MULG)
                yv_reg <= mul_p;
            else
            begin
                case (mul_idx_reg)
                    3'd0:    a_reg  <= mul_p;
                    3'd1:    t1_reg <= mul_p;
                    3'd2:    t2_reg <= mul_p;
                    3'd3:    b_reg  <= t1_reg - mul_p;
                    3'd4:    t3_reg <= mul_p;
                    3'd5:    t4_reg <= mul_p;
                    default: xv_reg <= t3_reg + mul_p;
                endcase
            end
        end
    end

    acs_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .vec   (cor_vec),
        .x0    (cor_x0),
        .y0    (cor_y0),
        .z0    (cor_z0),
        .x     (cor_x),
        .y     (cor_y),
        .z     (cor_z),
        .done  (cor_done)
    );

    acs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .done  (mul_done)
    );

    acs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

`include "angular_cone_search_macros.svh"

    `ACS_ASSERT_NOW(a_idle_no_unit, state_reg == S_IDLE, !issued_reg, "unit busy while idle")
    `ACS_ASSERT_NOW(a_idle_no_pend, state_reg == S_IDLE, !pend_valid_reg, "hit left buffered")
    `ACS_ASSERT_NEXT(a_end_flush, state_reg == S_Q_END && out_free,
        rsp_valid && rsp_word.last && !pend_valid_reg, "query end did not flush")

endmodule

// ===== verif/tb_angular_cone_search.sv =====
`timescale 1ns / 100ps

module tb_angular_cone_search;
    import acs_pkg::*;

    localparam int BODIES = 9;
    localparam int STEPS = 32;
    localparam longint LIMIT = 20000000;
    // command code with no meaning, must be ignored
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        in_word_t word;
        bit       drain;
    } pending_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    in_word_t  cmd_word;
    logic      rsp_valid;
    logic      rsp_stall;
    out_word_t rsp_word;

    pending_t  pending_q[$];
    out_word_t expected_q[$];

    logic [31:0]        table_ra[BODIES];
    logic signed [31:0] table_dec[BODIES];
    bit                 table_loaded;
    logic [31:0]        gen_ra[BODIES];
    logic signed [31:0] gen_dec[BODIES];

    longint cycles;
    int     errors;
    int     rx_count;
    int     send_gap;
    int     stall_left;
    int     hold_left;
    bit     held;
    bit     took;
    longint gain_inv;

    angular_cone_search #(.BODY_COUNT(BODIES), .CORDIC_STEPS(STEPS)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_word(cmd_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word(rsp_word)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // vectoring cordic, returns magnitude scaled by the cordic gain, accumulates angle into ang
    function automatic longint vec_rot(input longint xi, input longint yi, inout longint ang);
        longint x;
        longint y;
        longint nx;
        x = xi;
        y = yi;
        for (int i = 0; i < STEPS && i < 40; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                ang = ang + longint'(ATAN_TURNS[i]);
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                ang = ang - longint'(ATAN_TURNS[i]);
            end
            x = nx;
        end
        return x;
    endfunction

    function automatic longint qmul(input longint p, input longint q);
        return (p * q) >>> 30;
    endfunction

    function automatic void sine_cosine(input logic [31:0] angle, output longint s,
                                        output longint c);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = longint'($signed(angle));
        x = gain_inv;
        y = 0;
        flip = 0;
        if (z > 64'sd1073741824)
        begin
            z = z - 64'sd2147483648;
            flip = 1;
        end
        else if (z < -64'sd1073741824)
        begin
            z = z + 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < 40; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_TURNS[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_TURNS[i]);
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [31:0] great_circle(input logic [31:0] ra1, input logic [31:0] dec1,
                                                 input logic [31:0] ra2, input logic [31:0] dec2);
        longint sd1, cd1, sd2, cd2, sdra, cdra, a, b, x, y, t, z, m;
        logic [31:0] dra;
        dra = ra2 - ra1;
        z = 0;
        sine_cosine(dec1, sd1, cd1);
        sine_cosine(dec2, sd2, cd2);
        sine_cosine(dra, sdra, cdra);
        a = qmul(cd2, sdra);
        b = qmul(cd1, sd2) - qmul(qmul(sd1, cd2), cdra);
        x = qmul(sd1, sd2) + qmul(qmul(cd1, cd2), cdra);
        m = 0;
        y = qmul(vec_rot(a < 0 ? -a : a, b < 0 ? -b : b, m), gain_inv);
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = 64'sd1073741824;
        end
        m = vec_rot(x, y, z);
        if (z < 0)
            z = 0;
        if (z > 64'sd2147483648)
            z = 64'sd2147483648;
        return z[31:0];
    endfunction

    function automatic out_word_t make_result(input logic [1:0] st, input logic [3:0] idx,
                                              input logic [31:0] r, input logic [31:0] d,
                                              input logic [31:0] sep, input logic lst);
        out_word_t o;
        o.status = st;
        o.result_index = idx;
        o.body_ra = r;
        o.body_dec = d;
        o.separation = sep;
        o.last = lst;
        return o;
    endfunction

    task automatic expect_word(input out_word_t w);
        expected_q = {expected_q, w};
    endtask

    task automatic predict_search(input in_word_t w);
        int          hits;
        logic [31:0] sep;
        hits = 0;
        if (w.cmd == CMD_LOAD)
        begin
            if (w.slot < BODIES)
            begin
                table_ra[w.slot] = w.ra;
                table_dec[w.slot] = w.dec;
                table_loaded = 1;
            end
        end
        else if (w.cmd == CMD_QUERY)
        begin
            if (w.want_bodies && table_loaded)
            begin
                for (int i = 0; i < BODIES; i++)
                begin
                    sep = great_circle(w.ra, w.dec, table_ra[i], table_dec[i]);
                    if (sep <= w.radius)
                    begin
                        expect_word(make_result(ST_HIT, 4'(i), table_ra[i],
                                                table_dec[i], sep, 1'b0));
                        hits++;
                    end
                end
            end
            if (hits == 0)
                expect_word(make_result(ST_NONE, '0, '0, '0, '0, 1'b1));
            else
                expected_q[$].last = 1'b1;
        end
        else if (w.cmd == CMD_READ)
        begin
            if (table_loaded && w.slot < BODIES)
                expect_word(make_result(ST_READ_OK, w.slot,
                                        table_ra[w.slot],
                                        table_dec[w.slot], '0, 1'b1));
            else
                expect_word(make_result(ST_READ_MISS, w.slot, '0, '0, '0,
                                        1'b1));
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
        errors++;
    endtask

    task automatic queue_word(input logic [1:0] c, input logic [3:0] idx, input logic [31:0] r,
                              input logic [31:0] d, input logic [31:0] rad, input logic want,
                              input bit drain = 0);
        pending_t p;
        p.word.cmd = c;
        p.word.slot = idx;
        p.word.ra = r;
        p.word.dec = d;
        p.word.radius = rad;
        p.word.want_bodies = want;
        p.drain = drain;
        if (c == CMD_LOAD && idx < BODIES)
        begin
            gen_ra[idx] = r;
            gen_dec[idx] = d;
        end
        pending_q = {pending_q, p};
    endtask

    function automatic logic [31:0] rand_dec();
        return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endfunction

    // acceptance, result checking and the cycle limit
    always @(posedge clk)
    begin
        out_word_t e;
        cycles <= cycles + 1;
        took <= cmd_valid && !cmd_stall;
        if (rst_n && cmd_valid && !cmd_stall)
            predict_search(cmd_word);
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rx_count <= rx_count + 1;
            if (expected_q.size() == 0)
            begin
                $display("unexpected word at cycle %0d: %p", cycles, rsp_word);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (rsp_word.status !== e.status)
                    report("status", 32'(rsp_word.status), 32'(e.status));
                if (rsp_word.result_index !== e.result_index)
                    report("result_index", 32'(rsp_word.result_index), 32'(e.result_index));
                if (rsp_word.body_ra !== e.body_ra)
                    report("body_ra", rsp_word.body_ra, e.body_ra);
                if (rsp_word.body_dec !== e.body_dec)
                    report("body_dec", rsp_word.body_dec, e.body_dec);
                if (rsp_word.separation !== e.separation)
                    report("separation", rsp_word.separation, e.separation);
                if (rsp_word.last !== e.last)
                    report("last", 32'(rsp_word.last), 32'(e.last));
            end
        end
        if (cycles > LIMIT)
        begin
            $display("** angular_cone_search: FAILED **");
            $finish;
        end
    end

    // command driver
    always @(negedge clk)
    begin
        pending_t p;
        if (rst_n && !(cmd_valid && !took))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                cmd_valid <= 1'b0;
            end
            else if (pending_q.size() > 0 && !(pending_q[0].drain && expected_q.size() != 0))
            begin
                p = pending_q.pop_front();
                cmd_word <= p.word;
                cmd_valid <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                            : $urandom_range(1, 3);
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // response back-pressure, with one long hold-off once words are flowing and a window with no new random stalls
    always @(negedge clk)
    begin
        logic st;
        st = 1'b0;
        if (!held && rx_count >= 40)
        begin
            held = 1;
            hold_left = 4000;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            st = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            st = 1'b1;
        end
        else if (cycles > 20000 && cycles < 60000)
            st = 1'b0;
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = ($urandom_range(0, 12) == 0) ? $urandom_range(20, 100)
                                                      : $urandom_range(0, 3);
            st = 1'b1;
        end
        rsp_stall <= st;
    end

    initial
    begin
        logic [31:0] c_ra;
        logic [31:0] c_dec;
        logic [31:0] rad;
        int          k;
        int          b;
        longint      m;
        cycles = 0;
        errors = 0;
        rx_count = 0;
        send_gap = 0;
        stall_left = 0;
        hold_left = 0;
        held = 0;
        took = 0;
        table_loaded = 0;
        cmd_valid = 1'b0;
        rsp_stall = 1'b0;
        cmd_word = '0;
        rst_n = 1'b0;
        for (int i = 0; i < BODIES; i++)
        begin
            table_ra[i] = '0;
            table_dec[i] = '0;
            gen_ra[i] = '0;
            gen_dec[i] = '0;
        end
        m = 0;
        gain_inv = vec_rot(64'sd1073741824, 0, m);
        if (gain_inv < 1)
            gain_inv = 1;
        gain_inv = longint'(64'h1000_0000_0000_0000 / 64'(gain_inv));

        // empty table: reads miss, queries find nothing
        queue_word(CMD_READ, 4'd0, '0, '0, '0, 1'b0);
        queue_word(CMD_QUERY, 4'd0, '0, '0, 32'h8000_0000, 1'b1);
        queue_word(CMD_SPARE, 4'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_word(CMD_LOAD, 4'd15, 32'hFFFF_FFFF, 32'h4000_0000, '0, 1'b1);
        queue_word(CMD_READ, 4'd15, '0, '0, '0, 1'b1);
        queue_word(CMD_LOAD, 4'd0, 32'h0, 32'h0, '0, 1'b0);
        queue_word(CMD_LOAD, 4'd1, 32'hFFFF_FFFF, 32'h4000_0000, 32'hFFFF_FFFF, 1'b1);
        queue_word(CMD_LOAD, 4'd2, 32'h8000_0000, 32'hC000_0000, '0, 1'b0);
        queue_word(CMD_LOAD, 4'd3, 32'h4000_0000, 32'h2000_0000, '0, 1'b0);
        queue_word(CMD_LOAD, 4'd8, 32'hC000_0000, 32'hE000_0000, '0, 1'b0);
        queue_word(CMD_READ, 4'd8, '0, '0, '0, 1'b0);
        queue_word(CMD_READ, 4'd9, '0, '0, '0, 1'b0);
        queue_word(CMD_READ, 4'd1, '0, '0, '0, 1'b0);
        queue_word(CMD_QUERY, 4'd0, '0, '0, 32'h8000_0000, 1'b0);
        queue_word(CMD_QUERY, 4'd0, '0, '0, '0, 1'b1);
        queue_word(CMD_QUERY, 4'd0, '0, '0, 32'h8000_0000, 1'b1);
        queue_word(CMD_QUERY, 4'd15, 32'hFFFF_FFFF, 32'hC000_0000, 32'hFFFF_FFFF, 1'b1);
        queue_word(CMD_QUERY, 4'd0, 32'h4000_0000, 32'h2000_0000, 32'h0100_0000, 1'b1, 1);
        queue_word(CMD_QUERY, 4'd0, 32'h8000_0000, 32'h4000_0000, 32'h2000_0000, 1'b1);

        for (int n = 0; n < 450; n++)
        begin
            k = $urandom_range(0, 99);
            b = $urandom_range(0, 15);
            if (k < 35)
            begin
                if ($urandom_range(0, 1) == 0)
                    queue_word(CMD_LOAD, 4'(b), $urandom, rand_dec(), $urandom, 1'($urandom));
                else
                    queue_word(CMD_LOAD, 4'(b % BODIES), $urandom, rand_dec(), $urandom,
                               1'($urandom));
            end
            else if (k < 63)
            begin
                // centre near a stored body so cones catch something
                c_ra = gen_ra[b % BODIES] + ($urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
                c_dec = gen_dec[b % BODIES];
                if ($urandom_range(0, 3) == 0)
                begin
                    c_ra = $urandom;
                    c_dec = rand_dec();
                end
                case ($urandom_range(0, 3))
                    0: rad = $urandom_range(0, 32'h0400_0000);
                    1: rad = $urandom_range(0, 32'h2000_0000);
                    2: rad = $urandom_range(0, 32'h8000_0000);
                    default: rad = $urandom;
                endcase
                queue_word(CMD_QUERY, 4'($urandom), c_ra, c_dec, rad,
                           $urandom_range(0, 9) != 0, n == 200);
            end
            else if (k < 95)
                queue_word(CMD_READ, 4'(b), $urandom, $urandom, $urandom, 1'($urandom));
            else
                queue_word(CMD_SPARE, 4'(b), $urandom, $urandom, $urandom, 1'($urandom));
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_q.size() == 0 && !cmd_valid);
        wait (expected_q.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("** angular_cone_search: PASSED **");
        else
            $display("** angular_cone_search: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/acs_pkg.sv
src/acs_cordic.sv
src/acs_mul.sv
src/acs_div.sv
src/angular_cone_search.sv
verif/tb_angular_cone_search.sv
